// File: rtl/pram_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the palette RAM block.
// No dependencies; used by every module of the block.

package pram_pkg;

   localparam int PALETTE_WORDS_DEFAULT = 32;
   localparam int COLOR_BITS            = 15;
   localparam int WORDS_PER_ROW         = 4;

   localparam logic [7:0] INDEX_MASK = 8'hBF;

   localparam logic [COLOR_BITS-1:0] GRAY_TABLE [WORDS_PER_ROW] =
      '{15'h7FFF, 15'h56B5, 15'h294A, 15'h0000};

   typedef enum logic [2:0] {
      FUNC_BG_INDEX  = 3'd0,
      FUNC_BG_DATA   = 3'd1,
      FUNC_OBJ_INDEX = 3'd2,
      FUNC_OBJ_DATA  = 3'd3,
      FUNC_BG_SHADE  = 3'd4,
      FUNC_OBJ_SHADE0 = 3'd5,
      FUNC_OBJ_SHADE1 = 3'd6,
      FUNC_LOOKUP    = 3'd7
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [7:0]  data;
      logic        lookup_bank;
      logic [4:0]  lookup_entry;
   } req_type;

   typedef struct packed {
      logic [7:0]            bg_index_value;
      logic [7:0]            bg_data_value;
      logic [7:0]            obj_index_value;
      logic [7:0]            obj_data_value;
      logic [COLOR_BITS-1:0] color;
   } rsp_type;

   typedef logic [WORDS_PER_ROW-1:0][COLOR_BITS-1:0] row_type;

   function automatic row_type shade_row(input logic [7:0] shades);
      row_type r;
      for (int k = 0; k < WORDS_PER_ROW; k++) begin
         r[k] = GRAY_TABLE[shades[2*k +: 2]];
      end
      return r;
   endfunction

endpackage

// File: rtl/pram_mem.sv
`timescale 1ns / 1ps
// Palette storage: rows of four colors for both banks, one write and one read port.
// Per-row valid flags make every row read as zero after reset. Uses pram_pkg.

module pram_mem #(
   parameter int ADDR_BITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [ADDR_BITS-1:0]   rd_addr,
   output pram_pkg::row_type      rd_data,
   input  logic                   wr_en,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  pram_pkg::row_type      wr_data
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   pram_pkg::row_type mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   pram_pkg::row_type rd_q_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

// File: rtl/pram_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: index and data registers, read-modify-write of palette rows,
// auto-increment refresh with forwarding, shade mapping and lookups. Uses pram_pkg.

module pram_ctrl #(
   parameter int PALETTE_WORDS = pram_pkg::PALETTE_WORDS_DEFAULT,
   parameter int ROW_BITS      = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cgb_mode,
   input  logic                    start,
   output logic                    busy,
   input  pram_pkg::req_type       req_data,
   output logic                    rsp_valid,
   output pram_pkg::rsp_type       rsp_data,
   output logic                    mem_rd_en,
   output logic [ROW_BITS:0]       mem_rd_addr,
   input  pram_pkg::row_type       mem_rd_data,
   output logic                    mem_wr_en,
   output logic [ROW_BITS:0]       mem_wr_addr,
   output pram_pkg::row_type       mem_wr_data
);

   localparam logic [5:0] WORD_LIMIT = 6'(PALETTE_WORDS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_INC  = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   pram_pkg::req_type                req_ff, req_in;
   logic [4:0]                       word_ff, word_in;
   logic                             bank_ff, bank_in;
   logic                             fwd_ff, fwd_in;
   pram_pkg::row_type                fwd_row_ff, fwd_row_in;
   logic [7:0]                       bg_index_ff, bg_index_in;
   logic [7:0]                       bg_data_ff, bg_data_in;
   logic [7:0]                       obj_index_ff, obj_index_in;
   logic [7:0]                       obj_data_ff, obj_data_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pram_pkg::COLOR_BITS-1:0]  color_ff, color_in;

   pram_pkg::row_type                src_row;
   pram_pkg::row_type                mod_row;
   logic [pram_pkg::COLOR_BITS-1:0]  word_val;
   logic [pram_pkg::COLOR_BITS-1:0]  new_word;
   logic                             word_in_range;
   logic [7:0]                       cur_idx;
   logic [7:0]                       next_idx;
   logic [7:0]                       hi_byte;
   logic [7:0]                       lo_byte;
   logic [4:0]                       acc_word;
   logic                             acc_bank;

   assign src_row       = (state_ff == ST_INC && fwd_ff) ? fwd_row_ff : mem_rd_data;
   assign word_in_range = {1'b0, word_ff} < WORD_LIMIT;
   assign word_val      = word_in_range ? src_row[word_ff[1:0]] : '0;
   assign hi_byte       = {1'b0, word_val[14:8]};
   assign lo_byte       = word_val[7:0];
   assign cur_idx       = bank_ff ? obj_index_ff : bg_index_ff;
   assign next_idx      = (cur_idx + 8'd1) & pram_pkg::INDEX_MASK;
   assign new_word      = cur_idx[0] ? {req_ff.data[6:0], word_val[7:0]}
                                     : {word_val[14:8], req_ff.data};

   always_comb begin
      mod_row                 = src_row;
      mod_row[word_ff[1:0]]   = new_word;
   end

   always_comb begin
      acc_word = 5'd0;
      acc_bank = 1'b0;
      unique case (req_data.func) inside
         pram_pkg::FUNC_BG_INDEX: begin
            acc_word = req_data.data[5:1];
         end
         pram_pkg::FUNC_OBJ_INDEX: begin
            acc_word = req_data.data[5:1];
            acc_bank = 1'b1;
         end
         pram_pkg::FUNC_BG_DATA: begin
            acc_word = bg_index_ff[5:1];
         end
         pram_pkg::FUNC_OBJ_DATA: begin
            acc_word = obj_index_ff[5:1];
            acc_bank = 1'b1;
         end
         pram_pkg::FUNC_BG_SHADE: begin
            acc_word = 5'd0;
         end
         pram_pkg::FUNC_OBJ_SHADE0: begin
            acc_bank = 1'b1;
         end
         pram_pkg::FUNC_OBJ_SHADE1: begin
            acc_word = 5'd4;
            acc_bank = 1'b1;
         end
         pram_pkg::FUNC_LOOKUP: begin
            acc_word = req_data.lookup_entry;
            acc_bank = req_data.lookup_bank;
         end
         default: begin
            acc_word = 5'd0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      word_in      = word_ff;
      bank_in      = bank_ff;
      fwd_in       = fwd_ff;
      fwd_row_in   = fwd_row_ff;
      bg_index_in  = bg_index_ff;
      bg_data_in   = bg_data_ff;
      obj_index_in = obj_index_ff;
      obj_data_in  = obj_data_ff;
      rsp_valid_in = 1'b0;
      color_in     = color_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = {acc_bank, ROW_BITS'(acc_word[4:2])};
      mem_wr_en    = 1'b0;
      mem_wr_addr  = {bank_ff, ROW_BITS'(word_ff[4:2])};
      mem_wr_data  = mod_row;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in    = req_data;
               word_in   = acc_word;
               bank_in   = acc_bank;
               mem_rd_en = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            color_in     = '0;
            state_in     = ST_IDLE;
            case (req_ff.func) inside
               pram_pkg::FUNC_BG_INDEX, pram_pkg::FUNC_OBJ_INDEX: begin
                  if (bank_ff) begin
                     obj_index_in = cgb_mode ? (req_ff.data & pram_pkg::INDEX_MASK)
                                             : req_ff.data;
                     if (cgb_mode) begin
                        obj_data_in = req_ff.data[0] ? hi_byte : lo_byte;
                     end
                  end else begin
                     bg_index_in = cgb_mode ? (req_ff.data & pram_pkg::INDEX_MASK)
                                            : req_ff.data;
                     if (cgb_mode) begin
                        bg_data_in = req_ff.data[0] ? hi_byte : lo_byte;
                     end
                  end
               end
               pram_pkg::FUNC_BG_DATA, pram_pkg::FUNC_OBJ_DATA: begin
                  if (bank_ff) begin
                     obj_data_in = req_ff.data;
                  end else begin
                     bg_data_in = req_ff.data;
                  end
                  if (cgb_mode) begin
                     mem_wr_en = word_in_range;
                     if (cur_idx[7]) begin
                        if (bank_ff) begin
                           obj_index_in = next_idx;
                        end else begin
                           bg_index_in = next_idx;
                        end
                        word_in      = next_idx[5:1];
                        mem_rd_en    = 1'b1;
                        mem_rd_addr  = {bank_ff, ROW_BITS'(next_idx[5:3])};
                        fwd_in       = next_idx[5:3] == word_ff[4:2];
                        fwd_row_in   = word_in_range ? mod_row : src_row;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_INC;
                     end
                  end
               end
               pram_pkg::FUNC_BG_SHADE, pram_pkg::FUNC_OBJ_SHADE0,
               pram_pkg::FUNC_OBJ_SHADE1: begin
                  mem_wr_en   = !cgb_mode;
                  mem_wr_data = pram_pkg::shade_row(req_ff.data);
               end
               default: begin
                  color_in = word_val;
               end
            endcase
         end
         ST_INC: begin
            if (bank_ff) begin
               obj_data_in = cur_idx[0] ? hi_byte : lo_byte;
            end else begin
               bg_data_in = cur_idx[0] ? hi_byte : lo_byte;
            end
            color_in     = '0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bg_index_ff  <= '0;
         bg_data_ff   <= '0;
         obj_index_ff <= '0;
         obj_data_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bg_index_ff  <= bg_index_in;
         bg_data_ff   <= bg_data_in;
         obj_index_ff <= obj_index_in;
         obj_data_ff  <= obj_data_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      word_ff    <= word_in;
      bank_ff    <= bank_in;
      fwd_ff     <= fwd_in;
      fwd_row_ff <= fwd_row_in;
      color_ff   <= color_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.bg_index_value  = bg_index_ff;
      rsp_data.bg_data_value   = bg_data_ff;
      rsp_data.obj_index_value = obj_index_ff;
      rsp_data.obj_data_value  = obj_data_ff;
      rsp_data.color           = color_ff;
   end

endmodule

// File: rtl/palette_ram_index_autoinc.sv
`timescale 1ns / 1ps
// A response strobes as the request leaves the EXEC state, or the INC state for a data
// write that auto-increments. A new request is taken only while idle, once the last one
// has left the read-then-write pass of the row memory and its response has strobed.
// Reset clears the state, the index and data registers and the response strobe, and
// makes every palette color read as zero at once; the mode register resets to color
// mode. Responses cannot be stalled. Depends on pram_pkg, pram_mem and pram_ctrl.

module palette_ram_index_autoinc #(
   parameter int PALETTE_WORDS = pram_pkg::PALETTE_WORDS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  pram_pkg::req_type  req_data,
   output logic               rsp_valid,
   output pram_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic               csr_wdata
);

   localparam int ROWS      = (PALETTE_WORDS + pram_pkg::WORDS_PER_ROW - 1)
                              / pram_pkg::WORDS_PER_ROW;
   localparam int ROW_BITS  = $clog2(ROWS);
   localparam int ADDR_BITS = ROW_BITS + 1;

   logic                  cgb_mode_ff;
   logic                  mem_rd_en;
   logic [ADDR_BITS-1:0]  mem_rd_addr;
   pram_pkg::row_type     mem_rd_data;
   logic                  mem_wr_en;
   logic [ADDR_BITS-1:0]  mem_wr_addr;
   pram_pkg::row_type     mem_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cgb_mode_ff <= 1'b1;
      end else if (csr_we) begin
         cgb_mode_ff <= csr_wdata;
      end
   end

   pram_ctrl #(
      .PALETTE_WORDS (PALETTE_WORDS),
      .ROW_BITS      (ROW_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cgb_mode    (cgb_mode_ff),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   pram_mem #(
      .ADDR_BITS (ADDR_BITS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for palette_ram_index_autoinc: directed and random requests
// against an internal model of both palette banks, with mode changes and bus idling.
// Depends on pram_pkg and the palette_ram_index_autoinc RTL.

module testbench;
   import pram_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we;
   logic    csr_wdata;

   palette_ram_index_autoinc dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Palette model: bank 0 is background, bank 1 is objects.
   logic [COLOR_BITS-1:0] model_colors [2][32];
   logic [7:0]            model_index [2];
   logic [7:0]            model_data [2];
   bit                    model_color_mode;

   rsp_type expected_responses [$];
   int mismatches;
   int requests_sent;
   int lookups_sent;
   int responses_checked;
   int mode_writes;
   bit gaps_allowed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d responses outstanding.", expected_responses.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void model_reset();
      model_color_mode = 1'b1;
      for (int b = 0; b < 2; b++) begin
         model_index[b] = '0;
         model_data[b] = '0;
         for (int w = 0; w < 32; w++) begin
            model_colors[b][w] = '0;
         end
      end
   endfunction

   function automatic void index_load(int b, logic [7:0] v);
      logic [COLOR_BITS-1:0] word;
      word = model_colors[b][v[5:1]];
      model_index[b] = v & INDEX_MASK;
      model_data[b] = v[0] ? {1'b0, word[14:8]} : word[7:0];
   endfunction

   function automatic void data_store(int b, logic [7:0] v);
      logic [4:0] w;
      w = model_index[b][5:1];
      model_data[b] = v;
      if (model_index[b][0]) begin
         model_colors[b][w][14:8] = v[6:0];
      end else begin
         model_colors[b][w][7:0] = v;
      end
      if (model_index[b][7]) begin
         index_load(b, model_index[b] + 8'd1);
      end
   endfunction

   function automatic void shade_fill(int b, int base, logic [7:0] v);
      for (int k = 0; k < 4; k++) begin
         model_colors[b][base + k] = GRAY_TABLE[v[2*k +: 2]];
      end
   endfunction

   function automatic rsp_type predict_palette_response(req_type r);
      rsp_type rsp;
      rsp.color = '0;
      case (r.func)
         FUNC_BG_INDEX: begin
            if (model_color_mode) index_load(0, r.data);
            else model_index[0] = r.data;
         end
         FUNC_BG_DATA: begin
            if (model_color_mode) data_store(0, r.data);
            else model_data[0] = r.data;
         end
         FUNC_OBJ_INDEX: begin
            if (model_color_mode) index_load(1, r.data);
            else model_index[1] = r.data;
         end
         FUNC_OBJ_DATA: begin
            if (model_color_mode) data_store(1, r.data);
            else model_data[1] = r.data;
         end
         FUNC_BG_SHADE: begin
            if (!model_color_mode) shade_fill(0, 0, r.data);
         end
         FUNC_OBJ_SHADE0: begin
            if (!model_color_mode) shade_fill(1, 0, r.data);
         end
         FUNC_OBJ_SHADE1: begin
            if (!model_color_mode) shade_fill(1, 4, r.data);
         end
         FUNC_LOOKUP: begin
            rsp.color = model_colors[r.lookup_bank][r.lookup_entry];
         end
         default: begin
         end
      endcase
      rsp.bg_index_value  = model_index[0];
      rsp.bg_data_value   = model_data[0];
      rsp.obj_index_value = model_index[1];
      rsp.obj_data_value  = model_data[1];
      return rsp;
   endfunction

   function automatic req_type make_req(func_type f, logic [7:0] d, logic b, logic [4:0] e);
      req_type r;
      r.func = f;
      r.data = d;
      r.lookup_bank = b;
      r.lookup_entry = e;
      return r;
   endfunction

   function automatic req_type rand_req(func_type f);
      return make_req(f, 8'($urandom), 1'($urandom), 5'($urandom));
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] error: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = expected_responses.pop_front();
            check_field("bg_index_value", 16'(rsp_data.bg_index_value),
                        16'(want.bg_index_value));
            check_field("bg_data_value", 16'(rsp_data.bg_data_value),
                        16'(want.bg_data_value));
            check_field("obj_index_value", 16'(rsp_data.obj_index_value),
                        16'(want.obj_index_value));
            check_field("obj_data_value", 16'(rsp_data.obj_data_value),
                        16'(want.obj_data_value));
            check_field("color", 16'(rsp_data.color), 16'(want.color));
            responses_checked++;
         end
      end
   end

   task automatic send_request(req_type r);
      if (gaps_allowed && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_responses.push_back(predict_palette_response(r));
      requests_sent++;
      if (r.func == FUNC_LOOKUP) lookups_sent++;
   endtask

   task automatic drain_responses();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (expected_responses.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
   endtask

   task automatic set_palette_mode(bit m);
      drain_responses();
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      model_color_mode = m;
      mode_writes++;
   endtask

   task automatic test_color_registers();
      gaps_allowed = 1'b1;
      set_palette_mode(1'b1);
      send_request(make_req(FUNC_LOOKUP, 8'h00, 1'b0, 5'd0));
      // Word 31 high byte with auto-increment wraps to word 0 low byte.
      send_request(make_req(FUNC_BG_INDEX, 8'hFF, 1'b1, 5'd31));
      send_request(make_req(FUNC_BG_DATA, 8'hFF, 1'b0, 5'd0));
      send_request(make_req(FUNC_BG_DATA, 8'h00, 1'b1, 5'd31));
      send_request(make_req(FUNC_BG_DATA, 8'hAA, 1'b0, 5'd0));
      send_request(make_req(FUNC_OBJ_INDEX, 8'h7F, 1'b0, 5'd0));
      send_request(make_req(FUNC_OBJ_DATA, 8'h80, 1'b0, 5'd0));
      send_request(make_req(FUNC_OBJ_INDEX, 8'h3E, 1'b0, 5'd0));
      send_request(make_req(FUNC_OBJ_DATA, 8'h55, 1'b0, 5'd0));
      send_request(make_req(FUNC_LOOKUP, 8'hFF, 1'b1, 5'd31));
      send_request(make_req(FUNC_LOOKUP, 8'h00, 1'b0, 5'd31));
      // Shade writes are ignored in color mode.
      send_request(make_req(FUNC_BG_SHADE, 8'hE4, 1'b0, 5'd0));
      send_request(make_req(FUNC_OBJ_SHADE0, 8'h1B, 1'b0, 5'd0));
      send_request(make_req(FUNC_OBJ_SHADE1, 8'hFF, 1'b0, 5'd0));
      send_request(make_req(FUNC_LOOKUP, 8'h00, 1'b0, 5'd0));
   endtask

   task automatic test_mono_shades();
      set_palette_mode(1'b0);
      send_request(make_req(FUNC_BG_INDEX, 8'hFF, 1'b0, 5'd0));
      send_request(make_req(FUNC_BG_DATA, 8'hFF, 1'b0, 5'd0));
      send_request(make_req(FUNC_OBJ_INDEX, 8'h40, 1'b0, 5'd0));
      send_request(make_req(FUNC_OBJ_DATA, 8'h00, 1'b0, 5'd0));
      send_request(make_req(FUNC_BG_SHADE, 8'hE4, 1'b0, 5'd0));
      send_request(make_req(FUNC_OBJ_SHADE0, 8'h1B, 1'b0, 5'd0));
      send_request(make_req(FUNC_OBJ_SHADE1, 8'hFF, 1'b0, 5'd0));
      send_request(make_req(FUNC_LOOKUP, 8'h00, 1'b0, 5'd3));
      send_request(make_req(FUNC_LOOKUP, 8'h00, 1'b1, 5'd4));
      send_request(make_req(FUNC_OBJ_SHADE1, 8'h00, 1'b0, 5'd0));
      send_request(make_req(FUNC_LOOKUP, 8'hFF, 1'b1, 5'd7));
   endtask

   task automatic test_random_traffic(int count, bit gaps_on);
      int issued;
      int b;
      int n;
      logic [7:0] idx;
      req_type r;
      issued = 0;
      while (issued < count) begin
         gaps_allowed = gaps_on && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0, 1: begin
               b = $urandom_range(0, 1);
               idx = 8'($urandom);
               if ($urandom_range(0, 3) != 0) idx[7] = 1'b1;
               r = rand_req(b ? FUNC_OBJ_INDEX : FUNC_BG_INDEX);
               r.data = idx;
               send_request(r);
               n = $urandom_range(1, 10);
               repeat (n) send_request(rand_req(b ? FUNC_OBJ_DATA : FUNC_BG_DATA));
               issued += 1 + n;
               n = $urandom_range(1, 4);
               repeat (n) begin
                  r = rand_req(FUNC_LOOKUP);
                  r.lookup_bank = 1'(b);
                  r.lookup_entry = idx[5:1] + 5'($urandom_range(0, 5));
                  send_request(r);
               end
               issued += n;
            end
            2: begin
               send_request(rand_req(func_type'($urandom_range(4, 6))));
               n = $urandom_range(1, 4);
               repeat (n) begin
                  r = rand_req(FUNC_LOOKUP);
                  r.lookup_entry = 5'($urandom_range(0, 7));
                  send_request(r);
               end
               issued += 1 + n;
            end
            default: begin
               n = $urandom_range(1, 6);
               repeat (n) send_request(rand_req(func_type'($urandom_range(0, 7))));
               issued += n;
            end
         endcase
      end
   endtask

   initial begin
      model_reset();
      mismatches = 0;
      requests_sent = 0;
      lookups_sent = 0;
      responses_checked = 0;
      mode_writes = 0;
      gaps_allowed = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_wdata <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_color_registers();
      test_mono_shades();
      set_palette_mode(1'b1);
      test_random_traffic(200, 1'b1);
      set_palette_mode(1'b0);
      test_random_traffic(200, 1'b1);
      set_palette_mode(1'b1);
      test_random_traffic(200, 1'b1);
      set_palette_mode(1'b0);
      test_random_traffic(150, 1'b1);
      set_palette_mode(1'b1);
      test_random_traffic(200, 1'b0);
      drain_responses();

      if (expected_responses.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_responses.size()));
      end
      $display("Sent %0d requests (%0d lookups) across %0d mode writes.",
               requests_sent, lookups_sent, mode_writes);
      $display("Checked %0d responses; %0d field mismatches.", responses_checked, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: palette_ram_index_autoinc.f
rtl/pram_pkg.sv
rtl/pram_mem.sv
rtl/pram_ctrl.sv
rtl/palette_ram_index_autoinc.sv
sim/testbench.sv
